>>> sv/deq_pkg.sv
// package for the double-ended queue: sizes, codes and cell control types
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // input command codes
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_REAR  = 3'd3,
    CMD_SHOW      = 3'd4
  } deq_cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_stat_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  // controller states
  typedef enum logic {
    DQ_IDLE,
    DQ_SHOW
  } deq_state_t;

endpackage

>>> sv/deq_cell.sv
// one storage cell of the deque chain
module deq_cell
  import deq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]         pos,
  input  logic signed [DATA_W-1:0] left_d,
  input  logic signed [DATA_W-1:0] right_d,
  input  logic signed [DATA_W-1:0] head_d,
  input  logic signed [DATA_W-1:0] load_d,
  output logic signed [DATA_W-1:0] data_q
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]         pos_ext;

  assign pos_ext = CNT_W'(pos);

  // pick the new cell content from the broadcast operation
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_PUSH_FRONT: begin
        data_nxt = left_d;
      end
      CELL_PUSH_REAR: begin
        if (pos_ext == ctl.count) data_nxt = load_d;
      end
      CELL_POP_FRONT: begin
        data_nxt = right_d;
      end
      CELL_ROTATE: begin
        // occupied region rotates left, tail takes the old head
        if (pos_ext == ctl.count - CNT_W'(1)) data_nxt = head_d;
        else if (pos_ext < ctl.count)         data_nxt = right_d;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

>>> sv/double_ended_queue.sv
// top level of the double-ended queue: controller, cell chain and output register
//
//  channel   direction  ports
//  in        input      in_valid, in_ready, in_cmd, in_value
//  out       output     out_valid, out_ready, out_status, out_data, out_last
//
// a word is taken whenever the output register is free or being drained. a
// display streams all fill_count stored words, one per cycle while out is not
// stalled, by rotating the cell chain once around; no new word is taken meanwhile.
// reset clears the fill count, controller and output valid; cell contents are
// left as they are. a stall on out holds the output register and the chain.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  deq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  logic in_fire, out_free, show_step, show_last, full, empty;
  logic [CNT_W-1:0] count_m1;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == DQ_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign show_step = (state_r == DQ_SHOW) && out_free;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_m1  = count_r - CNT_W'(1);
  assign show_last = (CNT_W'(step_r) == count_m1);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_value;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_final
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    deq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (IDX_W'(i)),
      .left_d  (left_w),
      .right_d (right_w),
      .head_d  (cell_q[0]),
      .load_d  (in_value),
      .data_q  (cell_q[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DQ_IDLE: begin
        if (in_fire && (in_cmd == CMD_SHOW) && !empty) state_nxt = DQ_SHOW;
      end
      DQ_SHOW: begin
        if (show_step && show_last) state_nxt = DQ_IDLE;
      end
      default: state_nxt = DQ_IDLE;
    endcase
  end

  // chain control, fill count and result word
  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.count      = count_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    if (in_fire) begin
      unique case (in_cmd) inside
        CMD_INS_FRONT, CMD_INS_REAR: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            out_status_nxt = STAT_OK;
            ctl.op    = (in_cmd == CMD_INS_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_REAR;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_REM_FRONT, CMD_REM_REAR: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
            out_data_nxt   = '0;
          end else begin
            out_status_nxt = STAT_OK;
            count_nxt      = count_m1;
            if (in_cmd == CMD_REM_FRONT) begin
              out_data_nxt = cell_q[0];
              ctl.op       = CELL_POP_FRONT;
            end else begin
              out_data_nxt = cell_q[count_m1[IDX_W-1:0]];
            end
          end
        end
        CMD_SHOW: begin
          step_nxt = '0;
          if (empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EMPTY;
            out_data_nxt   = '0;
            out_last_nxt   = 1'b1;
          end
        end
        default: begin
          // unused codes produce nothing
        end
      endcase
    end
    // display: emit the head and rotate the chain
    if (show_step) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_data_nxt   = cell_q[0];
      out_last_nxt   = show_last;
      ctl.op         = CELL_ROTATE;
      step_nxt       = step_r + IDX_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DQ_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // a display only runs on a non-empty queue
  a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DQ_SHOW) |-> !empty)
    else $error("display running on empty queue");

  // an insert into a full queue leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (in_cmd == CMD_INS_FRONT || in_cmd == CMD_INS_REAR))
      |=> (count_r == $past(count_r)))
    else $error("dropped insert changed fill count");

  // the last displayed word ends the display and keeps the count
  a_show_end: assert property (@(posedge clk) disable iff (!rst_n)
    (show_step && show_last) |=> (state_r == DQ_IDLE) && out_valid && out_last
      && (count_r == $past(count_r)))
    else $error("display did not end cleanly");

endmodule
